@@ design/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Smoothed central difference: shared package
// Widths, configuration register codes, the configuration bundle and the
// output saturation function.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned WeightW  = 17;
  localparam int unsigned Gain1W   = 32;
  localparam int unsigned Gain2W   = 48;
  localparam int unsigned OutW     = 48;
  localparam int unsigned MagW     = 33;
  localparam int unsigned ChunkW   = 17;
  localparam int unsigned ProdW    = MagW + ChunkW;
  localparam int unsigned AccW     = ProdW + 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CFG_WEIGHT      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_RATE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INV_STEP_SQ = 2'd2;

  localparam logic [WeightW-1:0] WEIGHT_ONE = 17'h1_0000;
  localparam logic [OutW-1:0]    SAT_POS    = 48'h7FFF_FFFF_FFFF;
  localparam logic [OutW-1:0]    SAT_NEG    = 48'h8000_0000_0000;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [Gain1W-1:0]  half_rate;
    logic [Gain2W-1:0]  inv_step_sq;
  } scd_cfg_t;

  // Clamps a magnitude to the signed 48-bit range and applies the sign.
  function automatic logic [OutW-1:0] scd_saturate(input logic [AccW-1:0] mag,
                                                   input logic            neg);
    logic [AccW-1:0] limit;
    logic [OutW-1:0] res;
    limit = neg ? AccW'(SAT_NEG) : AccW'(SAT_POS);
    res   = (mag > limit) ? limit[OutW-1:0] : mag[OutW-1:0];
    return neg ? (~res + 48'd1) : res;
  endfunction

endpackage

@@ design/scd_mul.sv @@
// ----------------------------------------------------------------------------
// Smoothed central difference: shared multiplier
// Unsigned 33 by 17 bit multiplier with a registered product, shared by the
// smoothing step and by every partial product of the two gains.
// ----------------------------------------------------------------------------
module scd_mul (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [scd_pkg::MagW-1:0]  a_i,
  input  logic [scd_pkg::ChunkW-1:0] b_i,
  output logic [scd_pkg::ProdW-1:0] prod_o
);
  import scd_pkg::*;

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ design/scd_cfg.sv @@
// ----------------------------------------------------------------------------
// Smoothed central difference: configuration registers
// Holds the smoothing weight and the two derivative gains. The weight is
// clamped to one on write; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module scd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [scd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scd_pkg::CfgDataW-1:0] cfg_data_i,
  output scd_pkg::scd_cfg_t            cfg_o
);
  import scd_pkg::*;

  scd_cfg_t           cfg_q;
  logic [WeightW-1:0] weight_raw;
  logic [WeightW-1:0] weight_clamped;

  assign cfg_ready_o    = 1'b1;
  assign weight_raw     = cfg_data_i[WeightW-1:0];
  assign weight_clamped = (weight_raw > WEIGHT_ONE) ? WEIGHT_ONE : weight_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight      <= WEIGHT_ONE;
      cfg_q.half_rate   <= '0;
      cfg_q.inv_step_sq <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WEIGHT:      cfg_q.weight      <= weight_clamped;
        CFG_HALF_RATE:   cfg_q.half_rate   <= cfg_data_i[Gain1W-1:0];
        CFG_INV_STEP_SQ: cfg_q.inv_step_sq <= cfg_data_i[Gain2W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/smoothed_central_difference_top.sv @@
// ----------------------------------------------------------------------------
// Smoothed central difference: top level
// Each sample beat is smoothed by an exponential moving average and yields a
// central-difference rate and a second difference, both saturated to 48 bits.
// A new sample beat is taken only after the previous one has moved its result
// to the output register; the input is stalled while the sequencer is busy.
// The stalls are set by a small sequencer that drives one 33 by 17 bit
// multiplier six times per sample: once for the smoothing weight, twice for
// the 16-bit halves of the rate gain and three times for the 16-bit slices of
// the second-difference gain, each product registered and summed the cycle
// after. A finished result waits in the output register and does not block
// the next sample; only a fresh result held back by a stalled output delays
// the sequencer.
// ----------------------------------------------------------------------------
module smoothed_central_difference_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [scd_pkg::SampleW-1:0]  sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [scd_pkg::OutW-1:0]     first_derivative_o,
  output logic [scd_pkg::OutW-1:0]     second_derivative_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [scd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scd_pkg::CfgDataW-1:0] cfg_data_i
);
  import scd_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EMA_MUL  = 3'd1;
  localparam logic [2:0] ST_EMA_ACC  = 3'd2;
  localparam logic [2:0] ST_DIFF     = 3'd3;
  localparam logic [2:0] ST_MUL      = 3'd4;
  localparam logic [2:0] ST_ACC_LAST = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  localparam logic [2:0] LastStep = 3'd4;

  scd_cfg_t cfg;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q;

  logic [SampleW-1:0] newest_q, middle_q, oldest_q;
  logic [MagW-1:0]    dmag_q, mag1_q, mag2_q;
  logic               dneg_q, neg1_q, neg2_q;
  logic [AccW-1:0]    acc_q;
  logic [OutW-1:0]    res1_q;
  logic [OutW-1:0]    out1_q, out2_q;
  logic               out_valid_q;

  logic               in_accept;
  logic               done_fire;
  logic               mul_en;
  logic [MagW-1:0]    mul_a;
  logic [ChunkW-1:0]  mul_b;
  logic [ProdW-1:0]   prod;

  logic [MagW-1:0]    ema_diff;
  logic [MagW-1:0]    ema_mag;
  logic [ProdW:0]     ema_prod;
  logic [ProdW:0]     ema_rnd;
  logic [SampleW-1:0] smoothed;

  logic [MagW-1:0]    diff1;
  logic [MagW-1:0]    diff1_mag;
  logic [MagW:0]      diff2;
  logic [MagW:0]      diff2_neg;

  logic [ProdW:0]     first_rnd;
  logic [AccW-1:0]    acc_first;
  logic [AccW-1:0]    acc_add_lo;
  logic [AccW-1:0]    acc_add_hi;

  scd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  scd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign done_fire  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Smoothing: signed difference to the newest value, then rounding of the
  // weighted step half towards plus infinity.
  assign ema_diff = {sample_i[SampleW-1], sample_i} - {newest_q[SampleW-1], newest_q};
  assign ema_mag  = ema_diff[MagW-1] ? (~ema_diff + 33'd1) : ema_diff;
  assign ema_prod = dneg_q ? (~{1'b0, prod} + 51'd1) : {1'b0, prod};
  assign ema_rnd  = ema_prod + 51'd32768;
  assign smoothed = newest_q + ema_rnd[16 +: SampleW];

  assign diff1     = {newest_q[SampleW-1], newest_q} - {oldest_q[SampleW-1], oldest_q};
  assign diff1_mag = diff1[MagW-1] ? (~diff1 + 33'd1) : diff1;
  assign diff2     = {{2{oldest_q[SampleW-1]}}, oldest_q}
                   - {middle_q[SampleW-1], middle_q, 1'b0}
                   + {{2{newest_q[SampleW-1]}}, newest_q};
  assign diff2_neg = ~diff2 + 34'd1;

  assign first_rnd  = {1'b0, prod} + 51'd32768;
  assign acc_first  = AccW'(first_rnd[ProdW:16]);
  assign acc_add_lo = acc_q + AccW'(prod);
  assign acc_add_hi = acc_q + {prod, 16'd0};

  always_comb begin
    mul_en = (state_q == ST_EMA_MUL) || (state_q == ST_MUL);
    mul_a  = dmag_q;
    mul_b  = cfg.weight;
    if (state_q == ST_MUL) begin
      mul_a = (step_q < 3'd2) ? mag1_q : mag2_q;
      unique case (step_q)
        3'd0:    mul_b = {1'b0, cfg.half_rate[15:0]};
        3'd1:    mul_b = {1'b0, cfg.half_rate[31:16]};
        3'd2:    mul_b = {1'b0, cfg.inv_step_sq[15:0]};
        3'd3:    mul_b = {1'b0, cfg.inv_step_sq[31:16]};
        default: mul_b = {1'b0, cfg.inv_step_sq[47:32]};
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_accept) state_d = ST_EMA_MUL;
      ST_EMA_MUL:  state_d = ST_EMA_ACC;
      ST_EMA_ACC:  state_d = ST_DIFF;
      ST_DIFF:     state_d = ST_MUL;
      ST_MUL:      if (step_q == LastStep) state_d = ST_ACC_LAST;
      ST_ACC_LAST: state_d = ST_DONE;
      ST_DONE:     if (done_fire) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      newest_q    <= '0;
      middle_q    <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
      if (state_q == ST_EMA_ACC) begin
        oldest_q <= middle_q;
        middle_q <= newest_q;
        newest_q <= smoothed;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dmag_q <= ema_mag;
      dneg_q <= ema_diff[MagW-1];
    end
    if (state_q == ST_DIFF) begin
      mag1_q <= diff1_mag;
      neg1_q <= diff1[MagW-1];
      mag2_q <= diff2[MagW] ? diff2_neg[MagW-1:0] : diff2[MagW-1:0];
      neg2_q <= diff2[MagW];
    end
    if (state_q == ST_MUL) begin
      unique case (step_q)
        3'd1, 3'd3: acc_q <= acc_first;
        3'd2, 3'd4: acc_q <= acc_add_lo;
        default: begin
        end
      endcase
      if (step_q == 3'd3) begin
        res1_q <= scd_saturate(acc_q, neg1_q);
      end
    end
    if (state_q == ST_ACC_LAST) begin
      acc_q <= acc_add_hi;
    end
    if (done_fire) begin
      out1_q <= res1_q;
      out2_q <= scd_saturate(acc_q, neg2_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign first_derivative_o  = out1_q;
  assign second_derivative_o = out2_q;

endmodule

@@ design/scd_checker.sv @@
// ----------------------------------------------------------------------------
// Smoothed central difference: port checker
// Watches the top level's ports for handshake and sequencing slips, and is
// attached to the top level by the bind statement below.
// ----------------------------------------------------------------------------
module scd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [scd_pkg::OutW-1:0]     first_derivative_o,
  input logic [scd_pkg::OutW-1:0]     second_derivative_o
);

  // A result beat that is held back stays offered.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result beat withdrawn while stalled.");

  // A result beat that is held back keeps its payload.
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(first_derivative_o) && $stable(second_derivative_o))
    else $error("Result payload changed while stalled.");

  // Once a sample beat is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("Sample input reopened before the item was processed.");

  // A fresh result only emerges from an item in progress.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result beat appeared without an item in progress.");

endmodule

bind smoothed_central_difference_top scd_checker u_scd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .first_derivative_o  (first_derivative_o),
  .second_derivative_o (second_derivative_o)
);

@@ tb/sv/tb_smoothed_central_difference_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed central difference: self-checking testbench
// A queue of sample beats feeds a clocked driver, and a clocked monitor checks
// every result beat against a local model of the smoothing filter and the two
// difference gains. A short directed part covers the reset values, the
// extremes, saturation, rounding and the register special cases. Random
// sections follow, with different register settings and idling patterns and
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb_smoothed_central_difference_top;
  import scd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int CHUNK_ITEMS      = 103;
  localparam int DRAIN_CYCLES     = 16;
  localparam int LONG_HOLD_AT     = 1000;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OutW-1:0] rate;
    logic [OutW-1:0] accel;
  } derivative_pair_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SampleW-1:0]  sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OutW-1:0]     rate_out;
  logic [OutW-1:0]     accel_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic [WeightW-1:0]  weight_cfg = WEIGHT_ONE;
  logic [Gain1W-1:0]   rate_gain = '0;
  logic [Gain2W-1:0]   accel_gain = '0;
  logic signed [31:0]  newest_pos = '0;
  logic signed [31:0]  middle_pos = '0;
  logic signed [31:0]  oldest_pos = '0;

  logic [SampleW-1:0]  pending_samples[$];
  derivative_pair_t    expected_pairs[$];
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  fault_count = 0;
  int                  results_seen = 0;
  int                  hold_left = 0;
  bit                  long_hold_done = 1'b0;

  smoothed_central_difference_top dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .sample_i            (sample),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .first_derivative_o  (rate_out),
    .second_derivative_o (accel_out),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [OutW-1:0] scale_and_clamp(input longint diff,
                                                      input logic [Gain2W-1:0] gain);
    logic        neg;
    logic [63:0] mag;
    logic [95:0] prod;
    logic [95:0] lim;
    logic [47:0] res;
    neg  = diff < 0;
    mag  = neg ? -diff : diff;
    prod = {32'b0, mag} * {48'b0, gain} + 96'd32768;
    prod = prod >> 16;
    lim  = neg ? {48'b0, SAT_NEG} : {48'b0, SAT_POS};
    if (prod > lim) begin
      prod = lim;
    end
    res = prod[47:0];
    return neg ? -res : res;
  endfunction

  function automatic derivative_pair_t smooth_and_differentiate(input logic [SampleW-1:0] raw);
    longint           d;
    longint           prod;
    longint           s;
    derivative_pair_t pair;
    d    = longint'($signed(raw)) - longint'(newest_pos);
    prod = longint'(weight_cfg) * d + 64'sd32768;
    s    = longint'(newest_pos) + (prod >>> 16);
    oldest_pos = middle_pos;
    middle_pos = newest_pos;
    newest_pos = s[31:0];
    pair.rate  = scale_and_clamp(longint'(newest_pos) - longint'(oldest_pos),
                                 {16'b0, rate_gain});
    pair.accel = scale_and_clamp(longint'(oldest_pos) - 2 * longint'(middle_pos)
                                 + longint'(newest_pos), accel_gain);
    return pair;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_gain();
    logic [CfgDataW-1:0] g;
    g = CfgDataW'({$urandom, $urandom});
    case ($urandom_range(0, 4))
      0: g = '0;
      1: g = '1;
      2: g = 48'($urandom_range(1, 1 << 18));
      3: g = g >> $urandom_range(0, 47);
      default: ;
    endcase
    return g;
  endfunction

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WEIGHT: weight_cfg = (data[WeightW-1:0] > WEIGHT_ONE) ? WEIGHT_ONE
                                                                 : data[WeightW-1:0];
      CFG_HALF_RATE: rate_gain = data[Gain1W-1:0];
      CFG_INV_STEP_SQ: accel_gain = data[Gain2W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_samples.size() != 0 || expected_pairs.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_pairs.push_back(smooth_and_differentiate(sample));
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        sample   <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    derivative_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_pairs.size() == 0) begin
        if (fault_count < 10) begin
          $display("Unexpected result beat %0d: rate %h accel %h",
                   results_seen, rate_out, accel_out);
        end
        fault_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (want.rate !== rate_out || want.accel !== accel_out) begin
          if (fault_count < 10) begin
            $display("Mismatch on result beat %0d: rate exp %h got %h, accel exp %h got %h",
                     results_seen, want.rate, rate_out, want.accel, accel_out);
          end
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [SampleW-1:0]  track;
    logic [CfgDataW-1:0] wdata;
    int                  mode;
    track = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values first: full weight and zero gains, history starting at zero.
    pending_samples = '{32'h7FFF_FFFF, 32'h8000_0000};
    wait_for_drain();

    // Unity gains, with a weight write above one that must clamp.
    write_register(CFG_WEIGHT, 48'h0_0001_FFFF);
    write_register(CFG_HALF_RATE, 48'h0_0001_0000);
    write_register(CFG_INV_STEP_SQ, 48'h0_0001_0000);
    pending_samples = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000};
    wait_for_drain();

    // Largest gains drive both outputs into saturation; the unused index is ignored.
    write_register(CFG_HALF_RATE, 48'hFFFF_FFFF_FFFF);
    write_register(CFG_INV_STEP_SQ, 48'hFFFF_FFFF_FFFF);
    write_register(CFG_UNUSED, 48'h0000_0000_0000);
    pending_samples = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0000_0000, 32'h0001_0000};
    wait_for_drain();

    // Half weight and tiny gains exercise the rounding of both stages.
    write_register(CFG_WEIGHT, 48'h0_0000_8000);
    write_register(CFG_HALF_RATE, 48'h0_0000_0001);
    write_register(CFG_INV_STEP_SQ, 48'h0_0000_0001);
    pending_samples = '{32'h0000_0001, 32'hFFFF_FFFE, 32'h0001_8000, 32'hFFFF_0001};
    wait_for_drain();

    // Zero weight freezes the smoothed value.
    write_register(CFG_WEIGHT, 48'h0);
    write_register(CFG_HALF_RATE, 48'h0_0001_0000);
    pending_samples = '{32'h7FFF_FFFF, 32'h8000_0000};
    wait_for_drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 19 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        wait_for_drain();
        wdata = CfgDataW'({$urandom, $urandom});
        case ($urandom_range(0, 3))
          0: wdata = '0;
          1: wdata = 48'(WEIGHT_ONE);
          2: wdata = 48'($urandom_range(0, 65536));
          default: ;
        endcase
        write_register(CFG_WEIGHT, wdata);
        write_register(CFG_HALF_RATE, pick_gain());
        write_register(CFG_INV_STEP_SQ, pick_gain());
        if ($urandom_range(0, 3) == 0) begin
          write_register(CFG_UNUSED, CfgDataW'({$urandom, $urandom}));
        end
        mode = $urandom_range(0, 2);
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          case (mode)
            0: pending_samples.push_back($urandom);
            1: begin
              track = track + $urandom_range(0, 8192) - 32'd4096;
              pending_samples.push_back(track);
            end
            default: begin
              case ($urandom_range(0, 4))
                0: pending_samples.push_back(32'h7FFF_FFFF);
                1: pending_samples.push_back(32'h8000_0000);
                2: pending_samples.push_back(32'h0000_0000);
                3: pending_samples.push_back(32'hFFFF_FFFF);
                default: pending_samples.push_back($urandom);
              endcase
            end
          endcase
        end
      end
    end

    wait_for_drain();
    if (fault_count == 0 && expected_pairs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/scd_pkg.sv
design/scd_mul.sv
design/scd_cfg.sv
design/smoothed_central_difference_top.sv
design/scd_checker.sv
tb/sv/tb_smoothed_central_difference_top.sv
